@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_ON(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/qrv_pkg.sv @@
// Types and constants for the quaternion vector rotation pipeline.
package qrv_pkg;

  localparam int COMP_W    = 16;
  localparam int QPART_W   = COMP_W + 1;
  localparam int PROD_W    = 2 * QPART_W;
  localparam int TERM_W    = PROD_W;
  localparam int MV_W      = TERM_W + COMP_W;
  localparam int SUM_W     = MV_W + 2;
  localparam int FRAC_BITS = 28;
  localparam int RND_W     = SUM_W - FRAC_BITS;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [QPART_W-1:0] qpart_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [MV_W-1:0]    mv_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
    comp_t w;
  } quat_t;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
  } vec3_t;

  // 1.0 in Q.28 and half of it for round to nearest
  localparam term_t ONE_Q =
    {{(TERM_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam sum_t HALF_Q =
    {{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

endpackage

@@ src/qrv_matrix.sv @@
// Rotation matrix build: quaternion products, then the nine Q.28 matrix terms.
module qrv_matrix (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_conj,
  input  qrv_pkg::quat_t   in_quat,
  input  qrv_pkg::vec3_t   in_vec,
  output logic             out_valid,
  input  logic             out_ready,
  output qrv_pkg::term_t   out_mat [3][3],
  output qrv_pkg::vec3_t   out_vec
);

  // stage a: products of quaternion parts
  logic            a_valid;
  logic            a_ready;
  qrv_pkg::prod_t  xx, yy, zz, xy, xz, yz, xw, yw, zw;
  qrv_pkg::vec3_t  a_vec;

  // stage b: matrix terms
  logic            b_valid;
  logic            b_ready;
  qrv_pkg::term_t  b_mat [3][3];
  qrv_pkg::vec3_t  b_vec;

  qrv_pkg::qpart_t qw, qx, qy, qz;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    qw = qrv_pkg::qpart_t'(in_quat.w);
    qx = qrv_pkg::qpart_t'(in_quat.x);
    qy = qrv_pkg::qpart_t'(in_quat.y);
    qz = qrv_pkg::qpart_t'(in_quat.z);
    if (in_conj) begin
      qx = -qx;
      qy = -qy;
      qz = -qz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      xx    <= qx * qx;
      yy    <= qy * qy;
      zz    <= qz * qz;
      xy    <= qx * qy;
      xz    <= qx * qz;
      yz    <= qy * qz;
      xw    <= qx * qw;
      yw    <= qy * qw;
      zw    <= qz * qw;
      a_vec <= in_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_mat[0][0] <= qrv_pkg::ONE_Q - (yy <<< 1) - (zz <<< 1);
      b_mat[0][1] <= (xy <<< 1) - (zw <<< 1);
      b_mat[0][2] <= (xz <<< 1) + (yw <<< 1);
      b_mat[1][0] <= (xy <<< 1) + (zw <<< 1);
      b_mat[1][1] <= qrv_pkg::ONE_Q - (xx <<< 1) - (zz <<< 1);
      b_mat[1][2] <= (yz <<< 1) - (xw <<< 1);
      b_mat[2][0] <= (xz <<< 1) - (yw <<< 1);
      b_mat[2][1] <= (yz <<< 1) + (xw <<< 1);
      b_mat[2][2] <= qrv_pkg::ONE_Q - (xx <<< 1) - (yy <<< 1);
      b_vec       <= a_vec;
    end
  end

  assign out_valid = b_valid;
  assign out_mat   = b_mat;
  assign out_vec   = b_vec;

endmodule

@@ src/qrv_dot.sv @@
// Matrix times vector: products, rounded row sums, saturation to 16 bits.
module qrv_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qrv_pkg::term_t   in_mat [3][3],
  input  qrv_pkg::vec3_t   in_vec,
  output logic             out_valid,
  input  logic             out_ready,
  output qrv_pkg::comp_t   out_rot [3],
  output logic             out_sat
);

  // stage c: term * component
  logic            c_valid;
  logic            c_ready;
  qrv_pkg::mv_t    c_prod [3][3];

  // stage d: rounded row sums
  logic            d_valid;
  logic            d_ready;
  qrv_pkg::rnd_t   d_rnd [3];

  // stage e: saturated result
  logic            e_valid;
  logic            e_ready;
  qrv_pkg::comp_t  e_rot [3];
  logic            e_sat;

  qrv_pkg::comp_t  vcomp [3];
  qrv_pkg::sum_t   row_sum [3];
  qrv_pkg::comp_t  clip [3];
  logic [2:0]      over;

  assign e_ready  = !e_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  assign vcomp[0] = in_vec.x;
  assign vcomp[1] = in_vec.y;
  assign vcomp[2] = in_vec.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = qrv_pkg::sum_t'(c_prod[i][0]) + qrv_pkg::sum_t'(c_prod[i][1])
                 + qrv_pkg::sum_t'(c_prod[i][2]) + qrv_pkg::HALF_Q;
    end
  end

  // in range when the bits above the 16-bit sign all match it
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      over[i] = !((&d_rnd[i][qrv_pkg::RND_W-1:qrv_pkg::COMP_W-1]) ||
                  !(|d_rnd[i][qrv_pkg::RND_W-1:qrv_pkg::COMP_W-1]));
      if (over[i]) begin
        clip[i] = {d_rnd[i][qrv_pkg::RND_W-1],
                   {(qrv_pkg::COMP_W-1){~d_rnd[i][qrv_pkg::RND_W-1]}}};
      end else begin
        clip[i] = d_rnd[i][qrv_pkg::COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (e_ready) begin
        e_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c_prod[i][j] <= in_mat[i][j] * vcomp[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      for (int i = 0; i < 3; i++) begin
        d_rnd[i] <= row_sum[i][qrv_pkg::SUM_W-1:qrv_pkg::FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && d_valid) begin
      e_rot <= clip;
      e_sat <= |over;
    end
  end

  assign out_valid = e_valid;
  assign out_rot   = e_rot;
  assign out_sat   = e_sat;

endmodule

@@ src/quaternion_rotate_vector_top.sv @@
// Top level of the quaternion vector rotation pipeline.
// Rotates a signed 16-bit vector by a Q1.14 quaternion (or its conjugate when
// the tuser action bit is set) through the quaternion's rotation matrix.
// Five register stages: quaternion products, matrix terms, term * component
// multiplies, rounded row sums, saturation. One item per cycle is accepted and
// delivered while the output is not stalled. Each stage holds its item while the
// stage after it is full, so s_tready drops only once all five stages are full and
// the output is held off. Matrix terms are kept exact in Q.28; row sums are
// rounded to nearest with ties upward and saturated, which sets m_tuser.
`include "assert_macros.svh"

module quaternion_rotate_vector_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  input  logic [111:0]  s_tdata,
  // action
  input  logic [0:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // rot_x, rot_y, rot_z
  output logic [47:0]   m_tdata,
  // saturated
  output logic [0:0]    m_tuser
);

  qrv_pkg::quat_t  quat;
  qrv_pkg::vec3_t  vec;
  logic            mid_valid;
  logic            mid_ready;
  qrv_pkg::term_t  mid_mat [3][3];
  qrv_pkg::vec3_t  mid_vec;
  qrv_pkg::comp_t  rot [3];
  logic            sat;

  assign quat = s_tdata[63:0];
  assign vec  = s_tdata[111:64];

  qrv_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_conj   (s_tuser[0]),
    .in_quat   (quat),
    .in_vec    (vec),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_mat   (mid_mat),
    .out_vec   (mid_vec)
  );

  qrv_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_mat    (mid_mat),
    .in_vec    (mid_vec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rot   (rot),
    .out_sat   (sat)
  );

  assign m_tdata = {rot[2], rot[1], rot[0]};
  assign m_tuser = sat;

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid && !mid_valid,
                 "pipeline not empty after reset")
  `ASSERT_ON(a_mid_hold, clk, rst,
             mid_valid && !mid_ready |=> mid_valid && $stable(mid_vec),
             "matrix stage lost a stalled item")
  `ASSERT_ON(a_full_stall, clk, rst, !s_tready |-> mid_valid && m_tvalid && !m_tready,
             "input stalled with room in pipeline")

endmodule
